// ----- hw/rtl/kprpt_pkg.sv -----
// Shared types and constants for the keypad repeat and pulse timer block.
`default_nettype none
package kprpt_pkg;

    localparam int CmdW      = 2;
    localparam int BtnW      = 4;
    localparam int DelayW    = 8;
    localparam int CntW      = 16;
    localparam int ApbAddrW  = 3;
    localparam int ApbDataW  = 32;

    localparam logic [CmdW-1:0] CMD_PORT   = 2'd0;
    localparam logic [CmdW-1:0] CMD_REPEAT = 2'd1;
    localparam logic [CmdW-1:0] CMD_EDGE   = 2'd2;
    localparam logic [CmdW-1:0] CMD_SLOW   = 2'd3;

    localparam int BTN_EXIT   = 0;
    localparam int BTN_DOWN   = 1;
    localparam int BTN_UP     = 2;
    localparam int BTN_SELECT = 3;

    localparam logic [BtnW-1:0] BTN_NONE = 4'hF;

    localparam logic REG_INIT_DELAY  = 1'b0;
    localparam logic REG_IDLE_TIMEOUT = 1'b1;

    localparam logic [DelayW-1:0] INIT_DELAY_RST   = 8'd10;
    localparam logic [CntW-1:0]   IDLE_TIMEOUT_RST = 16'd680;

    typedef struct packed {
        logic [CmdW-1:0] cmd;
        logic [BtnW-1:0] button_levels;
    } t_item;

    typedef struct packed {
        logic [DelayW-1:0] init_delay;
        logic [CntW-1:0]   idle_timeout;
    } t_cfg;

    typedef struct packed {
        logic select_event;
        logic up_event;
        logic down_event;
        logic exit_event;
        logic timeout_event;
    } t_key_evt;

    typedef struct packed {
        logic            capture_valid;
        logic [CntW-1:0] low_ticks;
        logic [CntW-1:0] high_ticks;
        logic [CntW-1:0] edges_seen;
    } t_cap_res;

endpackage
`default_nettype wire

// ----- hw/rtl/kprpt_if.sv -----
// Valid/ready channel interfaces for input items and result items.
`default_nettype none
interface kprpt_in_if
    import kprpt_pkg::*;
;
    logic            valid;
    logic            ready;
    logic [CmdW-1:0] cmd;
    logic [BtnW-1:0] button_levels;

    modport source (output valid, output cmd, output button_levels, input ready);
    modport sink   (input valid, input cmd, input button_levels, output ready);
endinterface

interface kprpt_out_if
    import kprpt_pkg::*;
;
    logic            valid;
    logic            ready;
    logic            select_event;
    logic            up_event;
    logic            down_event;
    logic            exit_event;
    logic            timeout_event;
    logic            capture_valid;
    logic [CntW-1:0] low_ticks;
    logic [CntW-1:0] high_ticks;
    logic [CntW-1:0] edges_seen;

    modport source (
        output valid, output select_event, output up_event, output down_event,
        output exit_event, output timeout_event, output capture_valid,
        output low_ticks, output high_ticks, output edges_seen, input ready
    );
    modport sink (
        input valid, input select_event, input up_event, input down_event,
        input exit_event, input timeout_event, input capture_valid,
        input low_ticks, input high_ticks, input edges_seen, output ready
    );
endinterface
`default_nettype wire

// ----- hw/rtl/kprpt_cfg.sv -----
// APB configuration registers: initial delay and idle timeout.
`default_nettype none
module kprpt_cfg
    import kprpt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ApbAddrW-1:0] paddr,
    input  wire logic [ApbDataW-1:0] pwdata,
    output logic      [ApbDataW-1:0] prdata,
    output logic                     pready,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.init_delay   <= INIT_DELAY_RST;
            r_cfg.idle_timeout <= IDLE_TIMEOUT_RST;
        end else if (wr_en) begin
            case (paddr[2])
                REG_INIT_DELAY:   r_cfg.init_delay   <= pwdata[DelayW-1:0];
                REG_IDLE_TIMEOUT: r_cfg.idle_timeout <= pwdata[CntW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_INIT_DELAY:   prdata = {{(ApbDataW-DelayW){1'b0}}, r_cfg.init_delay};
            REG_IDLE_TIMEOUT: prdata = {{(ApbDataW-CntW){1'b0}}, r_cfg.idle_timeout};
            default:          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

// ----- hw/rtl/kprpt_keypad.sv -----
// Keypad qualifier: button latch, debounce, initial delay, repeat and idle timeout.
`default_nettype none
module kprpt_keypad
    import kprpt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_item i_item,
    input  wire t_cfg  i_cfg,
    output t_key_evt   o_key
);

    logic [BtnW-1:0]   r_latched, n_latched;
    logic              r_debounce, n_debounce;
    logic              r_in_delay, n_in_delay;
    logic [DelayW-1:0] r_delay_cnt, n_delay_cnt;
    logic              r_activity, n_activity;
    logic [CntW-1:0]   r_idle_cnt, n_idle_cnt;

    logic [DelayW-1:0] delay_inc;
    logic [CntW-1:0]   idle_inc;
    logic              ended;
    logic              fire;

    always_comb begin
        n_latched   = r_latched;
        n_debounce  = r_debounce;
        n_in_delay  = r_in_delay;
        n_delay_cnt = r_delay_cnt;
        n_activity  = r_activity;
        n_idle_cnt  = r_idle_cnt;
        o_key       = '0;
        delay_inc   = r_delay_cnt + DelayW'(1);
        idle_inc    = r_idle_cnt + CntW'(1);
        ended       = 1'b0;
        fire        = 1'b0;
        case (i_item.cmd)
            CMD_PORT: begin
                n_latched   = i_item.button_levels;
                n_debounce  = 1'b1;
                n_delay_cnt = '0;
                n_in_delay  = 1'b1;
                n_activity  = 1'b1;
            end
            CMD_REPEAT: begin
                if (r_latched != BTN_NONE) begin
                    if (r_in_delay) begin
                        n_delay_cnt = delay_inc;
                        ended       = (delay_inc == i_cfg.init_delay);
                        n_in_delay  = !ended;
                    end
                    fire = !ended && (!r_in_delay || r_debounce);
                    if (fire) begin
                        n_debounce         = 1'b0;
                        o_key.select_event = !i_item.button_levels[BTN_SELECT] && r_in_delay;
                        o_key.down_event   = !i_item.button_levels[BTN_DOWN];
                        o_key.up_event     = !i_item.button_levels[BTN_UP];
                        o_key.exit_event   = !i_item.button_levels[BTN_EXIT];
                    end
                end
            end
            CMD_SLOW: begin
                n_idle_cnt = r_activity ? '0 : idle_inc;
                n_activity = 1'b0;
                if (n_idle_cnt > i_cfg.idle_timeout) begin
                    n_idle_cnt          = '0;
                    o_key.timeout_event = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_latched   <= BTN_NONE;
            r_debounce  <= 1'b0;
            r_in_delay  <= 1'b0;
            r_delay_cnt <= '0;
            r_activity  <= 1'b0;
            r_idle_cnt  <= '0;
        end else if (i_step) begin
            r_latched   <= n_latched;
            r_debounce  <= n_debounce;
            r_in_delay  <= n_in_delay;
            r_delay_cnt <= n_delay_cnt;
            r_activity  <= n_activity;
            r_idle_cnt  <= n_idle_cnt;
        end
    end

endmodule
`default_nettype wire

// ----- hw/rtl/kprpt_timer.sv -----
// Pulse phase timer: phase counter, low/high lengths and edge total.
`default_nettype none
module kprpt_timer
    import kprpt_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_step,
    input  wire t_item i_item,
    output t_cap_res   o_cap
);

    logic [CntW-1:0] r_phase, n_phase;
    logic [CntW-1:0] r_low, n_low;
    logic [CntW-1:0] r_high, n_high;
    logic [CntW-1:0] r_edges, n_edges;
    logic            r_expect_rise, n_expect_rise;
    logic            cap;

    always_comb begin
        n_phase       = r_phase;
        n_low         = r_low;
        n_high        = r_high;
        n_edges       = r_edges;
        n_expect_rise = r_expect_rise;
        cap           = 1'b0;
        case (i_item.cmd)
            CMD_EDGE: begin
                n_edges       = r_edges + CntW'(1);
                n_expect_rise = !r_expect_rise;
                if (r_expect_rise) begin
                    n_low = r_phase;
                end else begin
                    n_high = r_phase;
                end
                n_phase = '0;
                cap     = 1'b1;
            end
            CMD_SLOW: begin
                n_phase = r_phase + CntW'(1);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase       <= '0;
            r_low         <= '0;
            r_high        <= '0;
            r_edges       <= '0;
            r_expect_rise <= 1'b1;
        end else if (i_step) begin
            r_phase       <= n_phase;
            r_low         <= n_low;
            r_high        <= n_high;
            r_edges       <= n_edges;
            r_expect_rise <= n_expect_rise;
        end
    end

    assign o_cap.capture_valid = cap;
    assign o_cap.low_ticks     = n_low;
    assign o_cap.high_ticks    = n_high;
    assign o_cap.edges_seen    = n_edges;

endmodule
`default_nettype wire

// ----- hw/rtl/keypad_repeat_and_pulse_timer.sv -----
// Top level: input register, keypad and timer logic, result register, APB registers.
//
//   channel  | dir | payload                                     | handshake
//   i_in     | in  | cmd, button_levels                          | valid/ready
//   o_out    | out | key/timeout/capture flags, low/high, edges  | valid/ready
//   APB      | in  | initial delay (0x0), idle timeout (0x4)     | psel/penable
//
// One item per cycle unless the output stalls; input register feeds result register.
// Throughput is set by the single state update between input and result registers.
// Synchronous active-low reset clears all control state and valid flags, not the data.
// A stalled output holds its beat; the input register still fills behind it.
`default_nettype none
module keypad_repeat_and_pulse_timer
    import kprpt_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    kprpt_in_if.sink                 i_in,
    kprpt_out_if.source              o_out,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [ApbAddrW-1:0] paddr,
    input  wire logic [ApbDataW-1:0] pwdata,
    output logic      [ApbDataW-1:0] prdata,
    output logic                     pready
);

    t_cfg     cfg;
    t_item    r_in;
    logic     r_in_valid;
    logic     r_out_valid;
    t_key_evt r_key, key;
    t_cap_res r_cap, cap;
    logic     adv;

    kprpt_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    assign adv        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_in.cmd           <= i_in.cmd;
            r_in.button_levels <= i_in.button_levels;
        end
    end

    kprpt_keypad u_keypad (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_item  (r_in),
        .i_cfg   (cfg),
        .o_key   (key)
    );

    kprpt_timer u_timer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (adv),
        .i_item  (r_in),
        .o_cap   (cap)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_key <= key;
            r_cap <= cap;
        end
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.select_event  = r_key.select_event;
    assign o_out.up_event      = r_key.up_event;
    assign o_out.down_event    = r_key.down_event;
    assign o_out.exit_event    = r_key.exit_event;
    assign o_out.timeout_event = r_key.timeout_event;
    assign o_out.capture_valid = r_cap.capture_valid;
    assign o_out.low_ticks     = r_cap.low_ticks;
    assign o_out.high_ticks    = r_cap.high_ticks;
    assign o_out.edges_seen    = r_cap.edges_seen;

    a_cap_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && cap.capture_valid |=> r_key == '0)
        else $error("capture beat carries a key or timeout flag");

    a_keys_on_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.cmd != CMD_REPEAT |=>
            !(r_key.select_event || r_key.up_event || r_key.down_event || r_key.exit_event))
        else $error("key flag on a non-repeat beat");

    a_timeout_on_slow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && r_in.cmd != CMD_SLOW |=> !r_key.timeout_event)
        else $error("timeout flag on a non-slow beat");

    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in))
        else $error("input register lost a waiting beat");

endmodule
`default_nettype wire
